>>> hdl/pst_pkg.sv
// Shared types and constants for the prime sieve table.
// Holds the map geometry, function codes and result status codes.
// No dependencies.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int MAP_AW = 16;   // map address bits, 65536 entries
	localparam int CNT_W  = 13;   // width of the prime count
	localparam int BASE_W = 9;    // sieve base, reaches at most 256 when it stops
	localparam logic [CNT_W-1:0] PRIME_CNT_MAX = 13'd6542;

	typedef enum logic {
		FUNC_BUILD = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_BUILD = 2'd1,
		STAT_ABOVE    = 2'd2
	} status_t;

endpackage

>>> hdl/prime_sieve_table.sv
// Prime sieve table top level: a 64K x 1 primality map with its sequencer.
// Depends on pst_pkg for map geometry, function codes and status codes.
// A query word reads its map bit on the accepting edge; its result enters the output register
// from ST_Q_RD, or from ST_RESP while the output is stalled, and only then, back in ST_IDLE,
// is the next word taken. A build word of limit L fills entries 0..L, walks the sieve bases,
// marks the multiples of each prime base and counts the map, all through the map memory;
// the input is stalled meanwhile, and a stalled output holds off the next word.
// After reset no map is built, the limit register holds 65535 and the map is unknown.
`timescale 1ns / 1ps

module prime_sieve_table
	import pst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: limit register write.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] index
	input  logic [0:0]  s_tuser,   // [0] func
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] is_prime_bit, [13:1] prime_count, [15:14] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// Sequencer states. FILL writes 0..limit with the initial prime pattern,
	// BASE/BASE_CHK walk the sieve bases, MARK clears the multiples of a prime
	// base, COUNT sums the map, Q_RD finishes a query, RESP waits for the
	// output register to free up.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_BASE,
		ST_BASE_CHK,
		ST_MARK,
		ST_COUNT,
		ST_Q_RD,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [15:0]          limit_q;      // configuration register
	logic [15:0]          blim_q;       // limit used by the last build
	logic                 map_built_q;
	logic [CNT_W-1:0]     pf_q;         // primes found by the last build
	func_t                func_q;
	logic [MAP_AW-1:0]    idx_q;
	logic [MAP_AW:0]      i_q;          // fill and count address, one bit spare
	logic [MAP_AW:0]      j_q;          // multiple being marked
	logic [BASE_W-1:0]    b_q;          // current sieve base
	logic [MAP_AW:0]      sq_q;         // b_q squared, kept by adding 2b+1
	logic [CNT_W-1:0]     cnt_q;
	logic                 cnt_v_q;      // rd_q holds a bit that must be counted
	logic                 m_tvalid_q;
	logic                 m_bit_q;
	logic [CNT_W-1:0]     m_cnt_q;
	status_t              m_stat_q;

	// Map memory, one write and one registered read per cycle.
	logic                 map_mem [2**MAP_AW];
	logic                 rd_q;
	logic                 mem_we;
	logic [MAP_AW-1:0]    mem_waddr;
	logic                 mem_wdata;
	logic                 rd_en;
	logic [MAP_AW-1:0]    rd_addr;

	logic [MAP_AW:0]      blim17;
	logic                 s_acc;
	logic                 out_free;
	logic                 out_load;
	logic [CNT_W-1:0]     cnt_next;
	logic [MAP_AW:0]      sq_next;
	logic                 res_bit;
	status_t              res_stat;

	assign blim17   = {1'b0, blim_q};
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	// The output register takes a new word when a result is ready and the old one is gone.
	assign out_load = (state_q == ST_Q_RD || state_q == ST_RESP) && out_free;
	assign cnt_next = cnt_q + {{(CNT_W-1){1'b0}}, rd_q & cnt_v_q};
	assign sq_next  = sq_q + {{(MAP_AW-BASE_W){1'b0}}, b_q, 1'b1};

	// Map port control: every access comes from exactly one state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[MAP_AW-1:0];
		mem_wdata = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = s_tdata[MAP_AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				rd_en = s_tvalid && (s_tuser[0] == FUNC_QUERY);
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = (i_q >= (MAP_AW+1)'(2));
			end
			ST_BASE: begin
				rd_en   = (sq_q <= blim17);
				rd_addr = {{(MAP_AW-BASE_W){1'b0}}, b_q};
			end
			ST_MARK: begin
				mem_we    = (j_q <= blim17);
				mem_waddr = j_q[MAP_AW-1:0];
			end
			ST_COUNT: begin
				rd_en   = (i_q <= blim17);
				rd_addr = i_q[MAP_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= map_mem[rd_addr];
		end
	end

	// Result of the item in flight. Entries above the built limit were never
	// written by that build and read as not prime.
	always_comb begin
		res_bit  = 1'b0;
		res_stat = STAT_OK;
		if (func_q == FUNC_QUERY) begin
			if (!map_built_q) begin
				res_stat = STAT_NO_BUILD;
			end else if (idx_q > limit_q) begin
				res_stat = STAT_ABOVE;
			end else begin
				res_bit = (idx_q <= blim_q) ? rd_q : 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= 16'hFFFF;
			blim_q      <= '0;
			map_built_q <= 1'b0;
			pf_q        <= '0;
			func_q      <= FUNC_BUILD;
			idx_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			b_q         <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			cnt_v_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_bit_q     <= 1'b0;
			m_cnt_q     <= '0;
			m_stat_q    <= STAT_OK;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						func_q <= func_t'(s_tuser[0]);
						idx_q  <= s_tdata[MAP_AW-1:0];
						if (s_tuser[0] == FUNC_BUILD) begin
							blim_q  <= limit_q;
							i_q     <= '0;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_FILL: begin
					i_q <= i_q + 1'b1;
					if (i_q[MAP_AW-1:0] == blim_q) begin
						b_q     <= BASE_W'(2);
						sq_q    <= (MAP_AW+1)'(4);
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (sq_q > blim17) begin
						i_q     <= (MAP_AW+1)'(2);
						cnt_q   <= '0;
						cnt_v_q <= 1'b0;
						state_q <= ST_COUNT;
					end else begin
						state_q <= ST_BASE_CHK;
					end
				end
				ST_BASE_CHK: begin
					if (rd_q) begin
						j_q     <= sq_q;
						state_q <= ST_MARK;
					end else begin
						b_q     <= b_q + 1'b1;
						sq_q    <= sq_next;
						state_q <= ST_BASE;
					end
				end
				ST_MARK: begin
					if (j_q <= blim17) begin
						j_q <= j_q + {{(MAP_AW+1-BASE_W){1'b0}}, b_q};
					end else begin
						b_q     <= b_q + 1'b1;
						sq_q    <= sq_next;
						state_q <= ST_BASE;
					end
				end
				ST_COUNT: begin
					cnt_q <= cnt_next;
					if (i_q <= blim17) begin
						i_q     <= i_q + 1'b1;
						cnt_v_q <= 1'b1;
					end else begin
						cnt_v_q     <= 1'b0;
						pf_q        <= cnt_next;
						map_built_q <= 1'b1;
						state_q     <= ST_RESP;
					end
				end
				ST_Q_RD, ST_RESP: begin
					if (out_free) begin
						m_bit_q    <= res_bit;
						m_cnt_q    <= pf_q;
						m_stat_q   <= res_stat;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_cnt_q, m_bit_q};
	assign m_tuser  = m_stat_q;

	// Map writes come only from the fill and marking passes.
	a_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_FILL || state_q == ST_MARK))
		else $error("map written outside fill or mark");

	// Marking never touches 0..3 nor anything above the built limit.
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ST_MARK) |-> (j_q >= (MAP_AW+1)'(4) && j_q <= blim17))
		else $error("composite mark out of range");

	// Once a map is built it stays built.
	a_built_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(map_built_q) |-> map_built_q)
		else $error("map_built dropped");

	// The count never exceeds the number of primes below 65536.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_cnt_q <= PRIME_CNT_MAX))
		else $error("prime count out of range");

	// A result with an error status never carries a prime flag.
	a_err_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_stat_q != STAT_OK) |-> !m_bit_q)
		else $error("prime flag set with error status");

endmodule
